FILE: src/lpd_pkg.sv
// lpd_pkg: shared types and constants for the laser range sensor packet decoder
// used by lpd_ctrl, lpd_datapath and lidar_packet_decoder
package lpd_pkg;

    // packet framing
    localparam logic [7:0]  SYNC_BYTE      = 8'hFA;
    localparam logic [4:0]  POS_INDEX      = 5'd0;
    localparam logic [4:0]  POS_SPEED_LO   = 5'd1;
    localparam logic [4:0]  POS_SPEED_HI   = 5'd2;
    localparam logic [4:0]  POS_FIRST_RD   = 5'd3;
    localparam logic [4:0]  POS_LAST_B0    = 5'd15;
    localparam logic [4:0]  POS_LAST_B1    = 5'd16;
    localparam logic [4:0]  POS_LAST_WORD  = 5'd18;
    localparam logic [4:0]  POS_CHK_HI     = 5'd20;
    localparam logic [15:0] ANGLE_BASE     = 16'h00A0;

    // field widths
    localparam int ACC_W    = 26;
    localparam int ANGLE_W  = 15;
    localparam int RANGE_W  = 14;
    localparam int SPEED_W  = 10;
    localparam int TDATA_W  = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REVS_PER_REPORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT  = 1'b1;
    localparam logic [7:0]           REVS_RESET          = 8'd1;
    localparam logic [13:0]          LIMIT_RESET         = 14'h3FFF;

    // result kinds
    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_SPEED = 1'b1;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_BODY,
        ST_CHECK,
        ST_READING,
        ST_SPEED
    } lpd_state_t;

    // controller to datapath
    typedef struct packed {
        logic       byte_en;    // capture the accepted byte at pos
        logic [4:0] pos;
        logic       step_en;    // evaluate one reading
        logic [1:0] rd_idx;
        logic       speed_load; // load the speed result
    } lpd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sync;
        logic chk_ok;
        logic out_free;
    } lpd_status_t;

endpackage

FILE: src/lidar_packet_decoder.sv
// lidar_packet_decoder: decodes 22-byte range sensor packets into readings.
// Input is accepted while hunting for sync or reading the packet body; after the
// last packet byte input is held off for the check and, on a good checksum, for
// four reading steps and the speed step, plus while the one-entry output register
// waits on m_tready. Reading i, if it passes, is loaded at step i, the speed result last.
// Reset (aresetn, synchronous) returns to sync hunting and reloads registers.
module lidar_packet_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream, tdata: rx_byte
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: angle_deg[14:0], range_value[28:15], rotation_speed[38:29], pad
    output logic [lpd_pkg::TDATA_W-1:0]         m_tdata,
    // tuser: kind
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lpd_pkg::*;

    lpd_cmd_t    cmd;
    lpd_status_t status;

    assign cfg_ready = 1'b1;

    lpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lpd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // bytes are captured only on an input transfer
    a_capture_on_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.byte_en |-> (s_tvalid && s_tready))
        else $error("byte captured without input transfer");

    // a result is loaded only when the output register can take it
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step_en || cmd.speed_load) |-> status.out_free)
        else $error("output register overwritten");

    // commands never overlap
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.byte_en, cmd.step_en, cmd.speed_load}))
        else $error("overlapping datapath commands");

    // the final result of a packet is the speed result
    a_last_is_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser[0] == KIND_SPEED))
        else $error("last result is not a speed update");
`endif

endmodule

FILE: src/lpd_ctrl.sv
// lpd_ctrl: controller state machine, byte position and reading counter
// depends on lpd_pkg
module lpd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lpd_pkg::lpd_status_t status,
    output lpd_pkg::lpd_cmd_t    cmd
);
    import lpd_pkg::*;

    lpd_state_t state_reg, state_next;
    logic [4:0] pos_reg, pos_next;
    logic [1:0] rd_reg, rd_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            pos_reg   <= 5'd0;
            rd_reg    <= 2'd0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            rd_reg    <= rd_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rd_next        = rd_reg;
        s_tready       = 1'b0;
        cmd.byte_en    = 1'b0;
        cmd.pos        = pos_reg;
        cmd.step_en    = 1'b0;
        cmd.rd_idx     = rd_reg;
        cmd.speed_load = 1'b0;
        unique case (state_reg)
            ST_HUNT: begin
                s_tready = 1'b1;
                if (s_tvalid && status.is_sync) begin
                    state_next = ST_BODY;
                    pos_next   = 5'd0;
                end
            end
            ST_BODY: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.byte_en = 1'b1;
                    if (pos_reg == POS_CHK_HI) begin
                        state_next = ST_CHECK;
                        pos_next   = 5'd0;
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            ST_CHECK: begin
                rd_next    = 2'd0;
                state_next = status.chk_ok ? ST_READING : ST_HUNT;
            end
            ST_READING: begin
                if (status.out_free) begin
                    cmd.step_en = 1'b1;
                    rd_next     = rd_reg + 2'd1;
                    if (rd_reg == 2'd3) begin
                        state_next = ST_SPEED;
                    end
                end
            end
            ST_SPEED: begin
                if (status.out_free) begin
                    cmd.speed_load = 1'b1;
                    state_next     = ST_HUNT;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule

FILE: src/lpd_datapath.sv
// lpd_datapath: byte capture, running checksum, reading filter, revolution
// counter, configuration registers and output register; depends on lpd_pkg
module lpd_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lpd_pkg::lpd_cmd_t                  cmd,
    output lpd_pkg::lpd_status_t               status,
    input  logic [7:0]                         s_tdata,
    input  logic                               cfg_valid,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lpd_pkg::TDATA_W-1:0]        m_tdata,
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast
);
    import lpd_pkg::*;

    // configuration
    logic [7:0]         revs_reg;
    logic [RANGE_W-1:0] limit_reg;

    // captured packet fields
    logic [ACC_W-1:0]   acc_reg;
    logic [7:0]         low_reg;
    logic [15:0]        got_reg;
    logic [7:0]         index_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [7:0]         rd_b0_reg [4];
    logic [7:0]         rd_b1_reg [4];

    // revolution tracking
    logic [7:0] rev_cnt_reg, rev_cnt_next;
    logic       send_en_reg, send_en_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic [RANGE_W-1:0] out_range_reg;
    logic [SPEED_W-1:0] out_speed_reg;
    logic               out_last_reg;

    logic [15:0]        word;
    logic [ANGLE_W:0]   fold_sum;
    logic [7:0]         b0, b1;
    logic [RANGE_W-1:0] rd_dist;
    logic [15:0]        diff;
    logic [15:0]        angle;
    logic [7:0]         cnt_inc;
    logic               reached;
    logic               send_eff;
    logic               pass;
    logic               emit;
    logic [2:0]         b1_slot;

    // checksum word: the sync byte is the low half of the first word
    assign word = (cmd.pos == POS_INDEX) ? {s_tdata, SYNC_BYTE} : {s_tdata, low_reg};
    assign b1_slot = cmd.pos[4:2] - 3'd1;

    // capture bytes and fold words into the checksum
    always_ff @(posedge aclk) begin
        if (cmd.byte_en) begin
            if (!cmd.pos[0] && cmd.pos <= POS_LAST_WORD) begin
                if (cmd.pos == POS_INDEX) begin
                    acc_reg <= ACC_W'(word);
                end else begin
                    acc_reg <= {acc_reg[ACC_W-2:0], 1'b0} + ACC_W'(word);
                end
            end
            if (cmd.pos[0]) begin
                low_reg <= s_tdata;
            end
            if (cmd.pos == POS_CHK_HI) begin
                got_reg <= {s_tdata, low_reg};
            end
            if (cmd.pos == POS_INDEX) begin
                index_reg <= s_tdata;
            end
            if (cmd.pos == POS_SPEED_LO) begin
                speed_reg[1:0] <= s_tdata[7:6];
            end
            if (cmd.pos == POS_SPEED_HI) begin
                speed_reg[SPEED_W-1:2] <= s_tdata;
            end
            if (cmd.pos[1:0] == 2'd3 && cmd.pos <= POS_LAST_B0) begin
                rd_b0_reg[cmd.pos[3:2]] <= s_tdata;
            end
            if (cmd.pos[1:0] == 2'd0 && cmd.pos != POS_INDEX && cmd.pos <= POS_LAST_B1) begin
                rd_b1_reg[b1_slot[1:0]] <= s_tdata;
            end
        end
    end

    // fold the accumulator to 15 bits and compare
    assign fold_sum = (ANGLE_W+1)'(acc_reg[ANGLE_W-1:0]) + (ANGLE_W+1)'(acc_reg[ACC_W-1:ANGLE_W]);

    // one reading: angle, revolution update and filter
    always_comb begin
        b0       = rd_b0_reg[cmd.rd_idx];
        b1       = rd_b1_reg[cmd.rd_idx];
        rd_dist  = {b1[5:0], b0};
        diff     = {8'd0, index_reg} - ANGLE_BASE;
        angle    = {diff[13:0], cmd.rd_idx};
        cnt_inc  = rev_cnt_reg + 8'd1;
        reached  = (cnt_inc >= revs_reg);
        send_eff = (angle == 16'd0) ? reached : send_en_reg;
        pass     = !b1[7] && !b1[6] && (rd_dist <= limit_reg);
        emit     = cmd.step_en && pass && send_eff;

        rev_cnt_next = rev_cnt_reg;
        send_en_next = send_en_reg;
        if (cmd.step_en && angle == 16'd0) begin
            rev_cnt_next = reached ? 8'd0 : cnt_inc;
            send_en_next = reached;
        end

        out_valid_next = out_valid_reg;
        if (emit || cmd.speed_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            revs_reg      <= REVS_RESET;
            limit_reg     <= LIMIT_RESET;
            rev_cnt_reg   <= 8'd0;
            send_en_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_REVS_PER_REPORT: revs_reg  <= cfg_data[7:0];
                    CFG_DISTANCE_LIMIT:  limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            rev_cnt_reg   <= rev_cnt_next;
            send_en_reg   <= send_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg  <= KIND_RANGE;
            out_angle_reg <= angle[ANGLE_W-1:0];
            out_range_reg <= rd_dist;
            out_speed_reg <= '0;
            out_last_reg  <= 1'b0;
        end else if (cmd.speed_load) begin
            out_kind_reg  <= KIND_SPEED;
            out_angle_reg <= '0;
            out_range_reg <= '0;
            out_speed_reg <= speed_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign status.is_sync  = (s_tdata == SYNC_BYTE);
    assign status.chk_ok   = !got_reg[15] && (got_reg[ANGLE_W-1:0] == fold_sum[ANGLE_W-1:0]);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_speed_reg, out_range_reg, out_angle_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: tb/tb_lidar_packet_decoder.sv
// tb_lidar_packet_decoder: self-checking bench for the range sensor packet decoder
// feeds byte streams and register writes and checks every result against a local model
// depends on lpd_pkg and lidar_packet_decoder
module tb_lidar_packet_decoder;
    import lpd_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 150;
    localparam int PHASE_PACKETS  = 4;
    localparam int RESULTS_WANTED = 60;
    localparam int PRINT_LIMIT    = 60;

    typedef enum logic [1:0] {CHK_GOOD, CHK_BAD, CHK_TOP_BIT} chk_mode_t;
    typedef enum logic [1:0] {WANT_MODEL, WANT_NOTHING, WANT_SPEED_ONLY} want_t;
    typedef enum logic {ROW_WRITE, ROW_PACKET} row_kind_t;

    typedef logic [21:0][7:0] frame_t;

    typedef struct packed {
        logic        kind;
        logic [14:0] angle;
        logic [13:0] range_val;
        logic [9:0]  speed;
        logic        last;
    } sample_t;

    // one directed step: a register write or a whole packet
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [13:0]           reg_val;
        logic [3:0]            lead;        // noise bytes ahead of the sync byte
        logic [7:0]            index;
        logic [15:0]           speed;
        logic [31:0]           dist_lo;     // reading i low byte at [8*i +: 8]
        logic [31:0]           dist_hi;     // reading i flag byte at [8*i +: 8]
        chk_mode_t             chk;
        want_t                 want;
        logic [9:0]            want_speed;
    } row_t;

    localparam int N_DIRECTED = 23;
    localparam row_t DIRECTED [N_DIRECTED] = '{
        // plain packet at angle zero, all distances zero
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd3, 8'hA0, 16'h0000,
          32'h00000000, 32'h00000000, CHK_GOOD, WANT_MODEL, 10'd0},
        // top index, top speed, top distance
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hF9, 16'hFFFF,
          32'hFFFFFFFF, 32'h3F3F3F3F, CHK_GOOD, WANT_MODEL, 10'd0},
        // every reading flagged invalid
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd1, 8'hB0, 16'h1234,
          32'h11223344, 32'h80808080, CHK_GOOD, WANT_SPEED_ONLY, 10'h048},
        // every reading flagged weak
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hB4, 16'hFFC0,
          32'hAABBCCDD, 32'h40404040, CHK_GOOD, WANT_SPEED_ONLY, 10'h3FF},
        // mixed flag patterns, all dropped
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hC0, 16'h0100,
          32'h01020304, 32'hFFBF7FC0, CHK_GOOD, WANT_SPEED_ONLY, 10'h004},
        // corrupted checksum
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd2, 8'hC4, 16'h5555,
          32'h12345678, 32'h01020304, CHK_BAD, WANT_NOTHING, 10'd0},
        // checksum word with its top bit set
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hC8, 16'hAAAA,
          32'h12345678, 32'h01020304, CHK_TOP_BIT, WANT_NOTHING, 10'd0},
        // sync bytes inside the packet body
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hFA, 16'hFAFA,
          32'hFAFAFAFA, 32'h3A3A3A3A, CHK_GOOD, WANT_MODEL, 10'd0},
        // index below the base, angle wraps
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'h00, 16'h0040,
          32'h01234567, 32'h0A0B0C0D, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'h9F, 16'h0080,
          32'h89ABCDEF, 32'h15263748, CHK_GOOD, WANT_MODEL, 10'd0},
        // lowest distance limit
        '{ROW_WRITE, CFG_DISTANCE_LIMIT, 14'd0, 4'd0, 8'h00, 16'h0000,
          32'h0, 32'h0, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hD0, 16'h1000,
          32'h00010002, 32'h00000000, CHK_GOOD, WANT_MODEL, 10'd0},
        // distances just around the limit
        '{ROW_WRITE, CFG_DISTANCE_LIMIT, 14'h1000, 4'd0, 8'h00, 16'h0000,
          32'h0, 32'h0, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hD4, 16'h2000,
          32'h00FF0100, 32'h000F1010, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_WRITE, CFG_DISTANCE_LIMIT, 14'h3FFF, 4'd0, 8'h00, 16'h0000,
          32'h0, 32'h0, CHK_GOOD, WANT_MODEL, 10'd0},
        // zero revolutions per report
        '{ROW_WRITE, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'h00, 16'h0000,
          32'h0, 32'h0, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd1, 8'hA0, 16'h3000,
          32'h10203040, 32'h01020304, CHK_GOOD, WANT_MODEL, 10'd0},
        // one report every third revolution
        '{ROW_WRITE, CFG_REVS_PER_REPORT, 14'd3, 4'd0, 8'h00, 16'h0000,
          32'h0, 32'h0, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hA0, 16'h3040,
          32'h11111111, 32'h01010101, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hA0, 16'h3080,
          32'h22222222, 32'h02020202, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hA0, 16'h30C0,
          32'h33333333, 32'h03030303, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_PACKET, CFG_REVS_PER_REPORT, 14'd0, 4'd0, 8'hA0, 16'h3100,
          32'h44444444, 32'h04040404, CHK_GOOD, WANT_MODEL, 10'd0},
        '{ROW_WRITE, CFG_REVS_PER_REPORT, 14'd1, 4'd0, 8'h00, 16'h0000,
          32'h0, 32'h0, CHK_GOOD, WANT_MODEL, 10'd0}
    };

    // dut ports
    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // decoder model state and its copy of the registers
    bit          pr_hunting;
    logic [4:0]  pr_pos;
    logic [7:0]  pr_store [21];
    logic [7:0]  pr_revs;
    bit          pr_send;
    logic [7:0]  pr_revs_per_report;
    logic [13:0] pr_limit;

    sample_t     packet_results [$];    // results of the byte just decoded
    sample_t     pending_results [$];   // results still owed by the dut

    int  mismatch_cnt;
    int  cycle_cnt;
    int  results_seen;
    int  hold_left;
    int  stall_left;
    bit  no_idle;

    lidar_packet_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // folded shift-and-add sum over the ten words in bytes 0..19
    function automatic logic [14:0] fold_sum(input frame_t f);
        logic [31:0] acc;
        acc = 32'd0;
        for (int t = 0; t < 10; t++)
            acc = (acc << 1) + {16'h0000, f[2*t+1], f[2*t]};
        return 15'(acc[14:0] + acc[31:15]);
    endfunction

    function automatic frame_t make_frame(input logic [7:0] index, input logic [15:0] speed,
                                          input logic [31:0] lo, input logic [31:0] hi,
                                          input chk_mode_t chk);
        frame_t      f;
        logic [15:0] sum;
        f[0] = SYNC_BYTE;
        f[1] = index;
        f[2] = speed[7:0];
        f[3] = speed[15:8];
        for (int i = 0; i < 4; i++) begin
            f[4+4*i] = lo[8*i +: 8];
            f[5+4*i] = hi[8*i +: 8];
            // signal quality bytes only feed the checksum
            f[6+4*i] = 8'($urandom);
            f[7+4*i] = 8'($urandom);
        end
        sum = {1'b0, fold_sum(f)};
        case (chk)
            CHK_BAD:     sum = sum ^ (16'h0001 << $urandom_range(0, 14));
            CHK_TOP_BIT: sum = sum | 16'h8000;
            default: ;
        endcase
        f[20] = sum[7:0];
        f[21] = sum[15:8];
        return f;
    endfunction

    // advance the decoder model by one byte, leaving its results in packet_results
    function automatic void decode_byte(input logic [7:0] b);
        frame_t      f;
        logic [15:0] diff;
        logic [15:0] ang;
        logic [15:0] spd;
        logic [13:0] d;
        logic [7:0]  flags;
        packet_results.delete();
        if (pr_hunting) begin
            if (b == SYNC_BYTE) begin
                pr_hunting = 1'b0;
                pr_pos = 5'd0;
            end
            return;
        end
        pr_store[pr_pos] = b;
        pr_pos = pr_pos + 5'd1;
        if (pr_pos < 5'd21)
            return;
        pr_hunting = 1'b1;
        pr_pos = 5'd0;
        f[0] = SYNC_BYTE;
        for (int k = 1; k < 22; k++)
            f[k] = pr_store[k-1];
        if ({f[21], f[20]} != {1'b0, fold_sum(f)})
            return;
        spd = {f[3], f[2]};
        diff = {8'h00, f[1]} - ANGLE_BASE;
        for (int i = 0; i < 4; i++) begin
            flags = f[5+4*i];
            d = {flags[5:0], f[4+4*i]};
            ang = {diff[13:0], 2'(i)};
            // revolution counting happens before any reading is dropped
            if (ang == 16'd0) begin
                pr_revs = pr_revs + 8'd1;
                if (pr_revs >= pr_revs_per_report) begin
                    pr_revs = 8'd0;
                    pr_send = 1'b1;
                end else begin
                    pr_send = 1'b0;
                end
            end
            if (!flags[7] && !flags[6] && d <= pr_limit && pr_send)
                packet_results.push_back('{KIND_RANGE, ang[14:0], d, 10'd0, 1'b0});
        end
        packet_results.push_back('{KIND_SPEED, 15'd0, 14'd0, spd[15:6], 1'b1});
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("cycle %0d: %s mismatch, got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
    endtask

    // one byte transfer on the input side, called and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input want_t want, input logic [9:0] want_speed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b);
        case (want)
            WANT_NOTHING: ;
            WANT_SPEED_ONLY:
                pending_results.push_back('{KIND_SPEED, 15'd0, 14'd0, want_speed, 1'b1});
            default:
                foreach (packet_results[k]) pending_results.push_back(packet_results[k]);
        endcase
        @(negedge aclk);
    endtask

    task automatic send_frame(input frame_t f, input int lead, input int cut, input want_t want,
                              input logic [9:0] want_speed);
        logic [7:0] nb;
        repeat (lead) begin
            do nb = 8'($urandom); while (nb == SYNC_BYTE);
            send_byte(nb, WANT_MODEL, 10'd0);
        end
        for (int k = 0; k < cut; k++)
            send_byte(f[k], (k == cut - 1) ? want : WANT_MODEL, want_speed);
    endtask

    // stop sending and let every owed result drain, then let a failed packet settle
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [13:0] val);
        pause_until_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_REVS_PER_REPORT)
            pr_revs_per_report = val[7:0];
        else if (idx == CFG_DISTANCE_LIMIT)
            pr_limit = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // cycle count and timeout
    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_lidar_packet_decoder: errors");
            $finish;
        end
    end

    // result side ready: long hold first, then the per-result stall
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare every result transfer with the oldest owed result
    always @(posedge aclk) begin : watch_results
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen = results_seen + 1;
            stall_left = no_idle ? 0 : $urandom_range(0, 4);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, tdata low", m_tdata[15:0], 16'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.kind)
                    report_mismatch("kind", 16'(m_tuser[0]), 16'(want.kind));
                if (m_tdata[14:0] !== want.angle)
                    report_mismatch("angle_deg", 16'(m_tdata[14:0]), 16'(want.angle));
                if (m_tdata[28:15] !== want.range_val)
                    report_mismatch("range_value", 16'(m_tdata[28:15]), 16'(want.range_val));
                if (m_tdata[38:29] !== want.speed)
                    report_mismatch("rotation_speed", 16'(m_tdata[38:29]), 16'(want.speed));
                if (m_tlast !== want.last)
                    report_mismatch("last", 16'(m_tlast), 16'(want.last));
            end
        end
    end

    initial begin : stimulus
        row_t        r;
        frame_t      f;
        logic [7:0]  index;
        logic [15:0] speed;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [13:0] d;
        logic [7:0]  revs;
        logic [13:0] lim;
        chk_mode_t   chk;
        int          sel;
        int          roll;
        int          cut;
        int          base_results;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_REVS_PER_REPORT;
        cfg_data  = '0;
        no_idle   = 1'b0;
        hold_left = 0;
        stall_left = 0;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        results_seen = 0;

        // model state after reset
        pr_hunting = 1'b1;
        pr_pos = 5'd0;
        foreach (pr_store[k]) pr_store[k] = 8'h00;
        pr_revs = 8'd0;
        pr_send = 1'b1;
        pr_revs_per_report = REVS_RESET;
        pr_limit = LIMIT_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        foreach (DIRECTED[n]) begin
            r = DIRECTED[n];
            if (r.kind == ROW_WRITE) begin
                write_reg(r.reg_idx, r.reg_val);
            end else begin
                f = make_frame(r.index, r.speed, r.dist_lo, r.dist_hi, r.chk);
                send_frame(f, r.lead, 22, r.want, r.want_speed);
            end
        end

        // random phases, each under its own register setting
        base_results = results_seen;
        for (int ph = 0; ph < 6 || results_seen - base_results < RESULTS_WANTED; ph++) begin
            case (ph % 6)
                0: begin revs = 8'd1;   lim = LIMIT_RESET; end
                1: begin revs = 8'd2;   lim = 14'($urandom_range(0, 16383)); end
                2: begin revs = 8'd0;   lim = 14'h3FFF; end
                3: begin revs = 8'd255; lim = LIMIT_RESET; end
                4: begin revs = 8'd3;   lim = 14'($urandom_range(1000, 9000)); end
                default: begin revs = 8'd1; lim = 14'd0; end
            endcase
            // upper data bits are junk for the revolutions register
            write_reg(CFG_REVS_PER_REPORT, {6'($urandom_range(0, 63)), revs});
            write_reg(CFG_DISTANCE_LIMIT, lim);
            no_idle = (ph % 6 == 3);
            // receiver holds off while packets keep coming in
            if (ph == 1)
                hold_left = LONG_HOLD;
            for (int n = 0; n < PHASE_PACKETS; n++) begin
                sel = $urandom_range(0, 99);
                index = ($urandom_range(0, 2) == 0) ? 8'hA0 : 8'($urandom);
                speed = 16'($urandom);
                for (int i = 0; i < 4; i++) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 6) begin
                        lo[8*i +: 8] = 8'($urandom);
                        hi[8*i +: 8] = {2'b00, 6'($urandom)};
                    end else if (roll < 8) begin
                        d = pr_limit + 14'($urandom_range(0, 1));
                        lo[8*i +: 8] = d[7:0];
                        hi[8*i +: 8] = {2'b00, d[13:8]};
                    end else begin
                        lo[8*i +: 8] = 8'($urandom);
                        hi[8*i +: 8] = 8'($urandom);
                    end
                end
                chk = (sel < 82) ? CHK_GOOD : (sel < 91) ? CHK_BAD : CHK_TOP_BIT;
                // a few packets are cut short and run into the next one
                cut = (sel >= 95) ? $urandom_range(1, 21) : 22;
                f = make_frame(index, speed, lo, hi, chk);
                send_frame(f, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, cut,
                           WANT_MODEL, 10'd0);
                if (ph == 2 && n == 1)
                    pause_until_drained();
            end
            // finish off any packet left open so the next write finds the block idle
            while (!pr_hunting)
                send_byte(8'h00, WANT_MODEL, 10'd0);
        end

        pause_until_drained();
        if (mismatch_cnt == 0)
            $display("tb_lidar_packet_decoder: clean");
        else
            $display("tb_lidar_packet_decoder: errors");
        $finish;
    end

endmodule
